### hw/rtl/lmfs_pkg.sv
// Shared types, constants and lookup tables for the LED matrix pattern store and row scan.
// Has no dependencies; every other file of the block imports it.
package lmfs_pkg;

   // Matrix geometry and scan timing defaults.
   localparam int NUM_MATRIX_ROWS_DEF = 12;
   localparam int NUM_MATRIX_COLS     = 11;
   localparam int TICKS_PER_ROW_DEF   = 8;

   // Field widths of the item formats.
   localparam int KIND_W       = 3;
   localparam int POS_W        = 4;
   localparam int WORD_IDX_W   = 5;
   localparam int DIGIT_W      = 4;
   localparam int ROW_SEL_W    = 4;
   localparam int BRIGHTNESS_W = 3;

   localparam int WORD_COUNT  = 27;
   localparam int GLYPH_COUNT = 10;

   localparam logic [BRIGHTNESS_W-1:0] BRIGHTNESS_RESET = 3'd7;

   // Item kinds; code seven is unused and is treated as a no-op.
   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR_ALL   = 3'd0,
      KIND_SET_PIXEL   = 3'd1,
      KIND_CLEAR_PIXEL = 3'd2,
      KIND_ADD_WORD    = 3'd3,
      KIND_REMOVE_WORD = 3'd4,
      KIND_DIGIT       = 3'd5,
      KIND_TICK        = 3'd6
   } kind_type;

   // One command as it travels from the input register to the pattern store.
   typedef struct packed {
      logic                  valid;
      kind_type              kind;
      logic [POS_W-1:0]      col;
      logic [POS_W-1:0]      row;
      logic [WORD_IDX_W-1:0] word_index;
      logic [DIGIT_W-1:0]    digit_value;
   } cmd_type;

   // Row of each word position entry.
   function automatic logic [POS_W-1:0] word_row(input logic [WORD_IDX_W-1:0] idx);
      logic [POS_W-1:0] r;
      case (idx)
         5'd0:  r = 4'd0;   5'd1:  r = 4'd0;   5'd2:  r = 4'd1;   5'd3:  r = 4'd2;
         5'd4:  r = 4'd2;   5'd5:  r = 4'd2;   5'd6:  r = 4'd3;   5'd7:  r = 4'd1;
         5'd8:  r = 4'd3;   5'd9:  r = 4'd4;   5'd10: r = 4'd4;   5'd11: r = 4'd5;
         5'd12: r = 4'd6;   5'd13: r = 4'd9;   5'd14: r = 4'd5;   5'd15: r = 4'd5;
         5'd16: r = 4'd7;   5'd17: r = 4'd8;   5'd18: r = 4'd9;   5'd19: r = 4'd7;
         5'd20: r = 4'd8;   5'd21: r = 4'd6;   5'd22: r = 4'd10;  5'd23: r = 4'd10;
         5'd24: r = 4'd9;   5'd25: r = 4'd5;   5'd26: r = 4'd10;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   // Column pattern of each word position entry; bit 15 is column zero.
   function automatic logic [15:0] word_cols(input logic [WORD_IDX_W-1:0] idx);
      logic [15:0] m;
      case (idx)
         5'd0:  m = 16'hDC00;  5'd1:  m = 16'h01E0;  5'd2:  m = 16'hE000;
         5'd3:  m = 16'h7800;  5'd4:  m = 16'h0780;  5'd5:  m = 16'h7F80;
         5'd6:  m = 16'h0FE0;  5'd7:  m = 16'h0FE0;  5'd8:  m = 16'hFFE0;
         5'd9:  m = 16'h7000;  5'd10: m = 16'h0F00;  5'd11: m = 16'hF000;
         5'd12: m = 16'hFFE0;  5'd13: m = 16'h03E0;  5'd14: m = 16'h01E0;
         5'd15: m = 16'h0780;  5'd16: m = 16'h7800;  5'd17: m = 16'hF000;
         5'd18: m = 16'h3C00;  5'd19: m = 16'h07C0;  5'd20: m = 16'h0FC0;
         5'd21: m = 16'h01E0;  5'd22: m = 16'h1E00;  5'd23: m = 16'hF000;
         5'd24: m = 16'hE000;  5'd25: m = 16'h01C0;  5'd26: m = 16'h00E0;
         default: m = 16'h0000;
      endcase
      return m;
   endfunction

   // Word mask in matrix bit order: bit c drives column c.
   function automatic logic [NUM_MATRIX_COLS-1:0] word_mask(
      input logic [WORD_IDX_W-1:0] idx);
      logic [15:0]                m16;
      logic [NUM_MATRIX_COLS-1:0] m;
      m16 = word_cols(idx);
      for (int c = 0; c < NUM_MATRIX_COLS; c++) begin
         m[c] = m16[15-c];
      end
      return m;
   endfunction

   // 3x5 digit glyphs, row-major, first pixel in bit 15.
   function automatic logic [15:0] glyph(input logic [DIGIT_W-1:0] d);
      logic [15:0] g;
      case (d)
         4'd0: g = 16'hF6DE;  4'd1: g = 16'h2492;  4'd2: g = 16'hE7CE;
         4'd3: g = 16'hE79E;  4'd4: g = 16'hB792;  4'd5: g = 16'hF39E;
         4'd6: g = 16'hF3DE;  4'd7: g = 16'hE492;  4'd8: g = 16'hF7DE;
         4'd9: g = 16'hF79E;
         default: g = 16'h0000;
      endcase
      return g;
   endfunction

endpackage

### hw/rtl/lmfs_pattern_store.sv
// Pattern store of the LED matrix: one register row per matrix row, updated by store commands.
// Depends on lmfs_pkg for the command struct, word ROM and digit glyphs.
module lmfs_pattern_store
   import lmfs_pkg::*;
#(
   parameter int ROW_COUNT = NUM_MATRIX_ROWS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  cmd_type                                 cmd,
   output logic [ROW_COUNT-1:0][NUM_MATRIX_COLS-1:0] rows
);

   logic [ROW_COUNT-1:0][NUM_MATRIX_COLS-1:0] rows_ff;
   logic [ROW_COUNT-1:0][NUM_MATRIX_COLS-1:0] rows_in;

   // Each row builds its own set and clear masks from the command.
   always_comb begin
      logic [NUM_MATRIX_COLS-1:0] set_m;
      logic [NUM_MATRIX_COLS-1:0] clr_m;
      logic [NUM_MATRIX_COLS-1:0] pix;
      logic [NUM_MATRIX_COLS-1:0] wmask;
      logic [15:0]                g;
      logic [4:0]                 rk;
      logic [4:0]                 cj;
      g     = glyph(cmd.digit_value);
      wmask = word_mask(cmd.word_index);
      pix   = NUM_MATRIX_COLS'(16'b1 << cmd.col);
      rk    = '0;
      cj    = '0;
      for (int r = 0; r < ROW_COUNT; r++) begin
         set_m = '0;
         clr_m = '0;
         if (cmd.valid) begin
            case (cmd.kind)
               KIND_CLEAR_ALL: begin
                  clr_m = '1;
               end
               KIND_SET_PIXEL, KIND_CLEAR_PIXEL: begin
                  if (cmd.row == POS_W'(r) && 32'(cmd.col) < NUM_MATRIX_COLS) begin
                     if (cmd.kind == KIND_SET_PIXEL) begin
                        set_m = pix;
                     end else begin
                        clr_m = pix;
                     end
                  end
               end
               KIND_ADD_WORD, KIND_REMOVE_WORD: begin
                  if (32'(cmd.word_index) < WORD_COUNT &&
                      word_row(cmd.word_index) == POS_W'(r)) begin
                     if (cmd.kind == KIND_ADD_WORD) begin
                        set_m = wmask;
                     end else begin
                        clr_m = wmask;
                     end
                  end
               end
               KIND_DIGIT: begin
                  if (32'(cmd.digit_value) < GLYPH_COUNT) begin
                     for (int k = 0; k < 5; k++) begin
                        for (int j = 0; j < 3; j++) begin
                           rk = 5'(cmd.row) + 5'(k);
                           cj = 5'(cmd.col) + 5'(j);
                           if (rk == 5'(r) && 32'(cj) < NUM_MATRIX_COLS) begin
                              if (g[15-(3*k+j)]) begin
                                 set_m = set_m | NUM_MATRIX_COLS'(32'b1 << cj);
                              end else begin
                                 clr_m = clr_m | NUM_MATRIX_COLS'(32'b1 << cj);
                              end
                           end
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         rows_in[r] = (rows_ff[r] & ~clr_m) | set_m;
      end
   end

   // The store clears at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
      end else begin
         rows_ff <= rows_in;
      end
   end

   assign rows = rows_ff;

endmodule

### hw/rtl/led_matrix_framebuffer_scan_core.sv
// Top level of the LED matrix pattern store with multiplexed row scan.
// Depends on lmfs_pkg and instantiates lmfs_pattern_store.
//
// Usage: the req channel carries commands. req_tuser holds the kind (clear all, set or
// clear a pixel, add or remove a word, stamp a digit, tick); req_tdata holds the pixel or
// digit position, the word index and the digit value. Every item gives exactly one item on
// the rsp channel with the row the scan drives, the row enable, the column lines and, on
// rsp_tlast, the frame end flag. A tick advances the scan: at phase zero the next
// non-empty row is latched; the row is lit for brightness_level+1 of TICKS_PER_ROW ticks.
// The csr channel writes brightness_level and is always ready.
// An accepted item is registered in the input register and moves into the result register
// when that register is free or its item is being taken. Throughput is one item per cycle
// while the receiver takes results, set by the single processing stage between the two registers.
// When the receiver stalls, the result register holds; one more item waits in the input
// register, after which req_tready drops until the result is taken.
// Reset clears the pattern store and scan state in the same cycle, sets brightness_level
// to seven and empties both registers; no clearing pass is needed.
module led_matrix_framebuffer_scan_core
   import lmfs_pkg::*;
#(
   parameter int ROW_COUNT     = NUM_MATRIX_ROWS_DEF,
   parameter int TICKS_PER_ROW = TICKS_PER_ROW_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // Command items.
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // tdata: col[3:0], row[7:4], word_index[12:8], digit_value[16:13], zero fill
   input  logic [23:0]             req_tdata,
   // tuser: kind[2:0]
   input  logic [KIND_W-1:0]       req_tuser,
   // Result items.
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // tdata: row_select[3:0], column_lines[14:4], zero fill
   output logic [15:0]             rsp_tdata,
   // tuser: row_enable[0]
   output logic                    rsp_tuser,
   // frame_end
   output logic                    rsp_tlast,
   // Brightness register write.
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [BRIGHTNESS_W-1:0] csr_data
);

   localparam int RW   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int SRW  = $clog2(ROW_COUNT + 1);
   localparam int PW   = $clog2(TICKS_PER_ROW);
   localparam int CMPW = (PW > BRIGHTNESS_W) ? PW : BRIGHTNESS_W;

   logic                                     in_valid_ff;
   cmd_type                                  in_cmd_ff;
   logic                                     process;
   cmd_type                                  store_cmd;
   logic [ROW_COUNT-1:0][NUM_MATRIX_COLS-1:0] rows;

   logic [BRIGHTNESS_W-1:0]    brightness_ff;
   logic [SRW-1:0]             scan_row_ff, scan_row_in;
   logic [PW-1:0]              scan_phase_ff, scan_phase_in;
   logic [NUM_MATRIX_COLS-1:0] latched_cols_ff, latched_cols_in;
   logic [ROW_SEL_W-1:0]       latched_row_ff, latched_row_in;
   logic                       row_active_ff, row_active_in;

   logic                       rsp_valid_ff;
   logic [ROW_SEL_W-1:0]       rsp_row_ff;
   logic                       rsp_en_ff, rsp_en_in;
   logic [NUM_MATRIX_COLS-1:0] rsp_cols_ff, rsp_cols_in;
   logic                       rsp_fend_ff, rsp_fend_in;

   logic [ROW_COUNT-1:0]       cand;
   logic [RW-1:0]              pick;

   // Handshakes: the input register moves on whenever the result register is free or being taken.
   assign process    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || process;
   assign csr_ready  = 1'b1;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_cmd_ff.valid       <= 1'b1;
         in_cmd_ff.kind        <= kind_type'(req_tuser);
         in_cmd_ff.col         <= req_tdata[3:0];
         in_cmd_ff.row         <= req_tdata[7:4];
         in_cmd_ff.word_index  <= req_tdata[12:8];
         in_cmd_ff.digit_value <= req_tdata[16:13];
      end
   end

   // The store sees the command only in the cycle it is processed.
   always_comb begin
      store_cmd       = in_cmd_ff;
      store_cmd.valid = process;
   end

   lmfs_pattern_store #(
      .ROW_COUNT(ROW_COUNT)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .cmd  (store_cmd),
      .rows (rows)
   );

   // Rows that are not empty, at or after the scan position, and the first of them.
   always_comb begin
      for (int r = 0; r < ROW_COUNT; r++) begin
         cand[r] = (rows[r] != '0) && (SRW'(r) >= scan_row_ff);
      end
      pick = '0;
      for (int r = ROW_COUNT - 1; r >= 0; r--) begin
         if (cand[r]) begin
            pick = RW'(r);
         end
      end
   end

   // Scan step for a tick; other kinds only report the latched row.
   always_comb begin
      scan_row_in     = scan_row_ff;
      scan_phase_in   = scan_phase_ff;
      latched_cols_in = latched_cols_ff;
      latched_row_in  = latched_row_ff;
      row_active_in   = row_active_ff;
      rsp_en_in       = 1'b0;
      rsp_cols_in     = '0;
      rsp_fend_in     = 1'b0;
      if (in_cmd_ff.kind == KIND_TICK) begin
         if (scan_phase_ff == '0) begin
            if (cand != '0) begin
               latched_row_in  = ROW_SEL_W'(pick);
               latched_cols_in = rows[pick];
               row_active_in   = 1'b1;
               scan_row_in     = SRW'(pick) + SRW'(1);
               scan_phase_in   = PW'(1);
               rsp_en_in       = 1'b1;
               rsp_cols_in     = rows[pick];
            end else begin
               rsp_fend_in   = 1'b1;
               scan_row_in   = '0;
               row_active_in = 1'b0;
            end
         end else begin
            if (row_active_ff && CMPW'(scan_phase_ff) <= CMPW'(brightness_ff)) begin
               rsp_en_in   = 1'b1;
               rsp_cols_in = latched_cols_ff;
            end
            if (scan_phase_ff == PW'(TICKS_PER_ROW - 1)) begin
               scan_phase_in = '0;
            end else begin
               scan_phase_in = scan_phase_ff + PW'(1);
            end
         end
      end
   end

   // Scan state and brightness register.
   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff   <= BRIGHTNESS_RESET;
         scan_row_ff     <= '0;
         scan_phase_ff   <= '0;
         latched_cols_ff <= '0;
         latched_row_ff  <= '0;
         row_active_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            brightness_ff <= csr_data;
         end
         if (process) begin
            scan_row_ff     <= scan_row_in;
            scan_phase_ff   <= scan_phase_in;
            latched_cols_ff <= latched_cols_in;
            latched_row_ff  <= latched_row_in;
            row_active_ff   <= row_active_in;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (process) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (process) begin
         rsp_row_ff  <= latched_row_in;
         rsp_en_ff   <= rsp_en_in;
         rsp_cols_ff <= rsp_cols_in;
         rsp_fend_ff <= rsp_fend_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_cols_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_en_ff;
   assign rsp_tlast  = rsp_fend_ff;

endmodule

### hw/rtl/lmfs_checker.sv
// Port-level checker for the LED matrix scan core, attached by the bind at the end.
// Depends on lmfs_pkg for field widths and the default row count.
module lmfs_checker
   import lmfs_pkg::*;
#(
   parameter int ROW_COUNT = NUM_MATRIX_ROWS_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // A frame end item is a dark tick.
   a_frame_end_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tuser && rsp_tdata[14:4] == '0)
      else $error("frame end item drives the matrix");

   // Column lines stay off while the row driver is off.
   a_cols_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[14:4] == '0)
      else $error("column lines driven with row disabled");

   // The reported row always lies inside the matrix.
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[3:0]) < ROW_COUNT)
      else $error("row select outside the matrix");

   // No result is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // A stalled result holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind led_matrix_framebuffer_scan_core lmfs_checker #(.ROW_COUNT(ROW_COUNT)) u_lmfs_checker (.*);

### tb/led_matrix_framebuffer_scan_core_tb.sv
// Self-checking testbench for led_matrix_framebuffer_scan_core: pattern edits and scan ticks
// are predicted in a scoreboard class and every result item is compared against it.
// Depends on lmfs_pkg for the item kinds and field widths.
module led_matrix_framebuffer_scan_core_tb;
   import lmfs_pkg::*;

   localparam int MATRIX_ROWS  = NUM_MATRIX_ROWS_DEF;
   localparam int ROW_TICKS    = TICKS_PER_ROW_DEF;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_COUNT  = 6;
   localparam int PHASE_ITEMS  = 250;
   localparam int REPORT_LIMIT = 10;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

   // One command item as the sender offers it.
   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [POS_W-1:0]      col;
      logic [POS_W-1:0]      row;
      logic [WORD_IDX_W-1:0] word_index;
      logic [DIGIT_W-1:0]    digit_value;
   } cmd_item_type;

   // One result item of the scan.
   typedef struct packed {
      logic [ROW_SEL_W-1:0]       row_select;
      logic                       row_enable;
      logic [NUM_MATRIX_COLS-1:0] column_lines;
      logic                       frame_end;
   } scan_out_type;

   // Tracks the pattern store and scan state and holds the scan outputs still owed.
   class scan_tracker;
      logic [NUM_MATRIX_COLS-1:0] pixel_rows [MATRIX_ROWS];
      int                         scan_row;
      int                         scan_phase;
      logic [NUM_MATRIX_COLS-1:0] latched_columns;
      logic [ROW_SEL_W-1:0]       latched_row;
      bit                         row_active;
      logic [BRIGHTNESS_W-1:0]    brightness;
      logic [POS_W-1:0]           rom_row [WORD_COUNT];
      logic [15:0]                rom_cols [WORD_COUNT];
      logic [15:0]                glyph_rom [GLYPH_COUNT];
      scan_out_type               expected_scans [$];
      int                         failures;

      function new();
         for (int r = 0; r < MATRIX_ROWS; r++) begin
            pixel_rows[r] = '0;
         end
         scan_row        = 0;
         scan_phase      = 0;
         latched_columns = '0;
         latched_row     = '0;
         row_active      = 1'b0;
         brightness      = 3'd7;
         failures        = 0;
         rom_row = '{4'd0, 4'd0, 4'd1, 4'd2, 4'd2, 4'd2, 4'd3, 4'd1, 4'd3, 4'd4, 4'd4,
                     4'd5, 4'd6, 4'd9, 4'd5, 4'd5, 4'd7, 4'd8, 4'd9, 4'd7, 4'd8, 4'd6,
                     4'd10, 4'd10, 4'd9, 4'd5, 4'd10};
         rom_cols = '{16'hDC00, 16'h01E0, 16'hE000, 16'h7800, 16'h0780, 16'h7F80,
                      16'h0FE0, 16'h0FE0, 16'hFFE0, 16'h7000, 16'h0F00, 16'hF000,
                      16'hFFE0, 16'h03E0, 16'h01E0, 16'h0780, 16'h7800, 16'hF000,
                      16'h3C00, 16'h07C0, 16'h0FC0, 16'h01E0, 16'h1E00, 16'hF000,
                      16'hE000, 16'h01C0, 16'h00E0};
         glyph_rom = '{16'hF6DE, 16'h2492, 16'hE7CE, 16'hE79E, 16'hB792,
                       16'hF39E, 16'hF3DE, 16'hE492, 16'hF7DE, 16'hF79E};
      endfunction

      function void set_brightness(logic [BRIGHTNESS_W-1:0] level);
         brightness = level;
      endfunction

      function int pending();
         return expected_scans.size();
      endfunction

      // Pixels outside the matrix are dropped.
      function void put_pixel(int c, int r, bit lit);
         if (c < NUM_MATRIX_COLS && r < MATRIX_ROWS) begin
            pixel_rows[r][c] = lit;
         end
      endfunction

      // Apply one accepted item to the store and scan and queue its scan output.
      function void apply_command(cmd_item_type c);
         scan_out_type               res;
         logic [NUM_MATRIX_COLS-1:0] mask;
         int                         r;
         res = '0;
         case (c.kind)
            KIND_CLEAR_ALL: begin
               for (int i = 0; i < MATRIX_ROWS; i++) begin
                  pixel_rows[i] = '0;
               end
            end
            KIND_SET_PIXEL, KIND_CLEAR_PIXEL: begin
               put_pixel(int'(c.col), int'(c.row), c.kind == KIND_SET_PIXEL);
            end
            KIND_ADD_WORD, KIND_REMOVE_WORD: begin
               if (c.word_index < WORD_COUNT) begin
                  r = int'(rom_row[c.word_index]);
                  for (int j = 0; j < NUM_MATRIX_COLS; j++) begin
                     mask[j] = rom_cols[c.word_index][15-j];
                  end
                  if (r < MATRIX_ROWS) begin
                     if (c.kind == KIND_ADD_WORD) begin
                        pixel_rows[r] = pixel_rows[r] | mask;
                     end else begin
                        pixel_rows[r] = pixel_rows[r] & ~mask;
                     end
                  end
               end
            end
            KIND_DIGIT: begin
               // The glyph overwrites its whole 3x5 box, zeros included.
               if (c.digit_value < GLYPH_COUNT) begin
                  for (int k = 0; k < 5; k++) begin
                     for (int j = 0; j < 3; j++) begin
                        put_pixel(int'(c.col) + j, int'(c.row) + k,
                                  glyph_rom[c.digit_value][15-(3*k+j)]);
                     end
                  end
               end
            end
            KIND_TICK: begin
               if (scan_phase == 0) begin
                  // Search for the next non-empty row; wrap with a blank tick if none.
                  r = scan_row;
                  while (r < MATRIX_ROWS && pixel_rows[r] == '0) begin
                     r++;
                  end
                  if (r < MATRIX_ROWS) begin
                     latched_row      = r[ROW_SEL_W-1:0];
                     latched_columns  = pixel_rows[r];
                     row_active       = 1'b1;
                     scan_row         = r + 1;
                     res.row_enable   = 1'b1;
                     res.column_lines = latched_columns;
                     scan_phase       = (ROW_TICKS > 1) ? 1 : 0;
                  end else begin
                     res.frame_end = 1'b1;
                     scan_row      = 0;
                     row_active    = 1'b0;
                  end
               end else begin
                  if (row_active && scan_phase <= int'(brightness)) begin
                     res.row_enable   = 1'b1;
                     res.column_lines = latched_columns;
                  end
                  scan_phase++;
                  if (scan_phase >= ROW_TICKS) begin
                     scan_phase = 0;
                  end
               end
            end
            default: begin
            end
         endcase
         res.row_select = latched_row;
         expected_scans.push_back(res);
      endfunction

      // Compare one accepted result item with the oldest expected scan output.
      function void check_scan(logic [ROW_SEL_W-1:0] row_select, logic row_enable,
                               logic [NUM_MATRIX_COLS-1:0] column_lines, logic frame_end);
         scan_out_type want;
         if (expected_scans.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("unexpected result item: row %0d en %0d cols %03h fend %0d",
                        row_select, row_enable, column_lines, frame_end);
            end
            return;
         end
         want = expected_scans.pop_front();
         if (row_select !== want.row_select || row_enable !== want.row_enable ||
             column_lines !== want.column_lines || frame_end !== want.frame_end) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("scan mismatch: expected row %0d en %0d cols %03h fend %0d",
                        want.row_select, want.row_enable, want.column_lines,
                        want.frame_end);
               $display("               actual   row %0d en %0d cols %03h fend %0d",
                        row_select, row_enable, column_lines, frame_end);
            end
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [23:0]             req_tdata;
   logic [KIND_W-1:0]       req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [15:0]             rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [BRIGHTNESS_W-1:0] csr_data;

   scan_tracker tracker;
   bit          hold_request;
   bit          no_idle;
   int          cycle_count;

   led_matrix_framebuffer_scan_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result monitor: every accepted result item is checked.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_scan(rsp_tdata[3:0], rsp_tuser, rsp_tdata[14:4], rsp_tlast);
      end
   end

   // Receiver: random stalls, mostly short, and one long hold-off when requested.
   initial begin
      int stall_left;
      int ready_left;
      int pick;
      stall_left = 0;
      ready_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0 && ready_left == 0) begin
            pick = $urandom_range(0, 99);
            if (hold_request) begin
               stall_left   = HOLD_CYCLES;
               hold_request = 1'b0;
            end else if (pick < 45) begin
               ready_left = $urandom_range(1, 40);
            end else if (pick < 90) begin
               stall_left = $urandom_range(1, 3);
            end else begin
               stall_left = $urandom_range(8, 40);
            end
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            ready_left--;
         end
      end
   end

   // Run limit.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Offer one item and wait until it is accepted.
   task automatic send_cmd(cmd_item_type c);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= c.kind;
      req_tdata  <= {7'd0, c.digit_value, c.word_index, c.row, c.col};
      do @(posedge clock); while (!req_tready);
      tracker.apply_command(c);
   endtask

   // Hold the input side idle for a number of cycles.
   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   function automatic int sender_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (no_idle || pick < 65) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic cmd_item_type make_cmd(logic [KIND_W-1:0] kind, int col, int row,
                                             int word_index, int digit_value);
      cmd_item_type c;
      c.kind        = kind;
      c.col         = col[POS_W-1:0];
      c.row         = row[POS_W-1:0];
      c.word_index  = word_index[WORD_IDX_W-1:0];
      c.digit_value = digit_value[DIGIT_W-1:0];
      return c;
   endfunction

   // Random item: mostly ticks and in-range edits, some out-of-range and unused codes.
   function automatic cmd_item_type random_cmd();
      cmd_item_type c;
      int           pick;
      c    = cmd_item_type'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 46) c.kind = KIND_TICK;
      else if (pick < 61) c.kind = KIND_SET_PIXEL;
      else if (pick < 69) c.kind = KIND_CLEAR_PIXEL;
      else if (pick < 80) c.kind = KIND_ADD_WORD;
      else if (pick < 86) c.kind = KIND_REMOVE_WORD;
      else if (pick < 95) c.kind = KIND_DIGIT;
      else if (pick < 98) c.kind = KIND_CLEAR_ALL;
      else c.kind = KIND_UNUSED;
      if ($urandom_range(0, 9) != 0) begin
         c.col         = POS_W'($urandom_range(0, NUM_MATRIX_COLS - 1));
         c.row         = POS_W'($urandom_range(0, MATRIX_ROWS - 1));
         c.word_index  = WORD_IDX_W'($urandom_range(0, WORD_COUNT - 1));
         c.digit_value = DIGIT_W'($urandom_range(0, GLYPH_COUNT - 1));
      end
      return c;
   endfunction

   // Write the brightness register once no result item is outstanding.
   task automatic write_brightness(logic [BRIGHTNESS_W-1:0] level);
      idle_cycles(1);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= level;
      do @(posedge clock); while (!csr_ready);
      tracker.set_brightness(level);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stimulus and end of run.
   initial begin
      logic [BRIGHTNESS_W-1:0] levels [PHASE_COUNT];
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      hold_request = 1'b0;
      no_idle      = 1'b0;
      tracker      = new();
      levels       = '{3'd7, 3'd0, 3'd7, 3'd4, 3'd1, 3'(($urandom_range(0, 7)))};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset brightness: empty scan, edges of the matrix,
      // out-of-range words and digits, the unused code, clipped glyphs.
      send_cmd(make_cmd(KIND_TICK, 0, 0, 0, 0));
      send_cmd(make_cmd(KIND_SET_PIXEL, 0, 0, 0, 0));
      send_cmd(make_cmd(KIND_SET_PIXEL, 10, 11, 0, 0));
      send_cmd(make_cmd(KIND_SET_PIXEL, 15, 15, 31, 15));
      send_cmd(make_cmd(KIND_TICK, 0, 0, 0, 0));
      send_cmd(make_cmd(KIND_ADD_WORD, 0, 0, 26, 0));
      send_cmd(make_cmd(KIND_ADD_WORD, 0, 0, 8, 0));
      send_cmd(make_cmd(KIND_ADD_WORD, 0, 0, 31, 0));
      send_cmd(make_cmd(KIND_REMOVE_WORD, 0, 0, 8, 0));
      send_cmd(make_cmd(KIND_DIGIT, 9, 9, 0, 8));
      send_cmd(make_cmd(KIND_DIGIT, 0, 0, 0, 15));
      send_cmd(make_cmd(KIND_UNUSED, 15, 15, 31, 15));
      send_cmd(make_cmd(KIND_CLEAR_PIXEL, 0, 0, 0, 0));
      send_cmd(make_cmd(KIND_TICK, 0, 0, 0, 0));
      for (int d = 0; d < GLYPH_COUNT; d++) begin
         send_cmd(make_cmd(KIND_DIGIT, d, d % 8, 0, d));
      end
      send_cmd(make_cmd(KIND_CLEAR_ALL, 0, 0, 0, 0));
      send_cmd(make_cmd(KIND_TICK, 0, 0, 0, 0));

      // Random phases, each at its own brightness; one phase runs without gaps
      // and one starts with a long receiver hold-off.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_brightness(levels[p]);
         no_idle = (p == 3);
         if (p == 2) begin
            hold_request = 1'b1;
            no_idle      = 1'b1;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_cmd(random_cmd());
            if (p == 2 && i == 60) begin
               no_idle = 1'b0;
            end
            idle_cycles(sender_gap());
         end
      end

      idle_cycles(1);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
